/* hw/rtl/auto_block_tracker_top_macros.svh */
// assertion helpers, clocked on clk_i and held off during reset
`ifndef AUTO_BLOCK_TRACKER_TOP_MACROS_SVH
`define AUTO_BLOCK_TRACKER_TOP_MACROS_SVH
`define ABT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ABT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

/* hw/rtl/abt_pkg.sv */
package abt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic {
    OP_HIT  = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_HIT  = 1'b0,
    KIND_RULE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DISABLED = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_TIMEOUT   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_TICK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic        opcode;
    logic        is_ip6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] table_index;
    logic [7:0]  action_code;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic        rule_add;
    logic        out_is_ip6;
    logic [63:0] out_addr_high;
    logic [63:0] out_addr_low;
    logic [15:0] out_table_index;
    logic [7:0]  out_action_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    opcode_e     op;
    logic        is_ip6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] table_index;
    logic [7:0]  action_code;
  } cmd_t;

  typedef struct packed {
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] tbl;
    logic [7:0]  action;
    logic [15:0] hit_count;
    logic        blocked;
    logic [15:0] seconds_left;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } cmd_hs_t;

endpackage

/* hw/rtl/auto_block_tracker_top.sv */
// channel   | signals                          | handshake
// ----------+----------------------------------+-------------------------------
// command   | start, busy, in_i                | taken when start && !busy
// result    | res_valid_o, res_o               | one-cycle strobe, no stall
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i | written when cfg_we_i is high
//
// in the back end a hit is answered without a table walk while tracking is off; else
// one entry of the table is compared per cycle until the key is found or the table ends
// a tick checks one entry per cycle, then a flush
// a two-item command queue sits between the front and the back end
// results appear in the cycle after they are decided; the receiver cannot stall
// reset clears the table's valid bits and enable at once, and sets threshold to 5 and timeout to 300
module auto_block_tracker_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  abt_pkg::in_item_t              in_i,
  output logic                           res_valid_o,
  output abt_pkg::out_item_t             res_o,
  input  logic                           cfg_we_i,
  input  logic [abt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [abt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  abt_pkg::cmd_hs_t hs;
  abt_pkg::cmd_t    cmd;
  logic             cmd_ready;

  abt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cmd_ready_i (cmd_ready),
    .hs_o        (hs),
    .cmd_o       (cmd)
  );

  abt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .hs_i        (hs),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* hw/rtl/abt_front.sv */
`include "auto_block_tracker_top_macros.svh"

module abt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  abt_pkg::in_item_t   in_i,
  input  logic                cmd_ready_i,
  output abt_pkg::cmd_hs_t    hs_o,
  output abt_pkg::cmd_t       cmd_o
);

  abt_pkg::cmd_t                q_mem [abt_pkg::QDEPTH];
  logic [abt_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [abt_pkg::QCNT_W-1:0]   count_q, count_d;
  abt_pkg::cmd_t                norm;
  logic                         push, pop;

  always_comb begin
    norm.op          = abt_pkg::opcode_e'(in_i.opcode);
    norm.is_ip6      = in_i.is_ip6;
    norm.addr_high   = in_i.is_ip6 ? in_i.addr_high : 64'd0;
    norm.addr_low    = in_i.is_ip6 ? in_i.addr_low : {32'd0, in_i.addr_low[31:0]};
    norm.table_index = in_i.table_index;
    norm.action_code = in_i.action_code;
  end

  assign busy     = (count_q == abt_pkg::QCNT_W'(abt_pkg::QDEPTH));
  assign push     = start && !busy;
  assign hs_o.valid = (count_q != '0);
  assign hs_o.ready = cmd_ready_i;
  assign pop      = hs_o.valid && cmd_ready_i;
  assign cmd_o    = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + abt_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + abt_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + abt_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - abt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= norm;
    end
  end

  `ABT_ASSERT(a_count_range, count_q <= abt_pkg::QCNT_W'(abt_pkg::QDEPTH), "queue count out of range")
  `ABT_NEVER(a_push_full, start && busy && (count_d != count_q) && !pop, "queue grew while full")
  `ABT_NEVER(a_pop_empty, pop && (count_q == '0), "pop from an empty queue")

endmodule

/* hw/rtl/abt_back.sv */
`include "auto_block_tracker_top_macros.svh"

module abt_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [abt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [abt_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  abt_pkg::cmd_hs_t                    hs_i,
  input  abt_pkg::cmd_t                       cmd_i,
  output logic                                cmd_ready_o,
  output logic                                res_valid_o,
  output abt_pkg::out_item_t                  res_o
);

  abt_pkg::state_e             state_q, state_d;
  logic                        enable_q;
  logic [15:0]                 thr_q, tmo_q;
  logic [abt_pkg::ENTRIES-1:0] valid_q, valid_d;
  abt_pkg::entry_t             ent_q [abt_pkg::ENTRIES];
  abt_pkg::entry_t             rd_q;
  abt_pkg::cmd_t               cur_q, cur_d;
  logic [abt_pkg::IDX_W-1:0]   idx_q, idx_d, free_idx_q, free_idx_d, alloc_idx;
  logic                        free_found_q, free_found_d;
  logic                        pend_valid_q, pend_valid_d;
  abt_pkg::out_item_t          pend_q, pend_d, out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic                        we, alloc_en;
  logic [abt_pkg::IDX_W-1:0]   waddr;
  abt_pkg::entry_t             wdata, e, upd;
  logic                        v, match, last_idx, is_add;
  logic [15:0]                 arm, cnt_inc;
  abt_pkg::out_item_t          hit_res, rule_res;

  assign e        = rd_q;
  assign v        = valid_q[idx_q];
  assign match    = v && (e.family == cur_q.is_ip6) && (e.tbl == cur_q.table_index)
                    && (e.addr_high == cur_q.addr_high) && (e.addr_low == cur_q.addr_low);
  assign last_idx = (idx_q == abt_pkg::IDX_W'(abt_pkg::ENTRIES - 1));
  assign arm      = (tmo_q == 16'd0) ? 16'd1 : tmo_q;
  assign cnt_inc  = (e.hit_count == 16'hFFFF) ? e.hit_count : e.hit_count + 16'd1;
  assign is_add   = (e.hit_count >= thr_q) && !e.blocked;
  assign alloc_idx = free_found_q ? free_idx_q : idx_q;
  assign cmd_ready_o = (state_q == abt_pkg::ST_IDLE);

  always_comb begin
    hit_res      = '0;
    hit_res.kind = abt_pkg::KIND_HIT;
    hit_res.last = 1'b1;
    rule_res                 = '0;
    rule_res.kind            = abt_pkg::KIND_RULE;
    rule_res.status          = abt_pkg::STATUS_OK;
    rule_res.rule_add        = is_add;
    rule_res.out_is_ip6      = e.family;
    rule_res.out_addr_high   = e.addr_high;
    rule_res.out_addr_low    = e.addr_low;
    rule_res.out_table_index = e.tbl;
    rule_res.out_action_code = e.action;
  end

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = 1'b0;
    out_d        = out_q;
    valid_d      = valid_q;
    we           = 1'b0;
    alloc_en     = 1'b0;
    waddr        = idx_q;
    upd          = e;
    wdata        = e;

    unique case (state_q)
      abt_pkg::ST_IDLE: begin
        if (hs_i.valid) begin
          cur_d        = cmd_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          pend_valid_d = 1'b0;
          if (cmd_i.op == abt_pkg::OP_TICK) begin
            state_d = abt_pkg::ST_TICK;
          end else if (!enable_q) begin
            out_valid_d  = 1'b1;
            out_d        = hit_res;
            out_d.status = abt_pkg::STATUS_DISABLED;
          end else begin
            state_d = abt_pkg::ST_HIT;
          end
        end
      end
      abt_pkg::ST_HIT: begin
        if (match) begin
          upd.hit_count = cnt_inc;
          if ((cnt_inc >= thr_q) && !e.blocked) begin
            upd.seconds_left = 16'd1;
          end
          we          = 1'b1;
          wdata       = upd;
          out_valid_d = 1'b1;
          out_d       = hit_res;
          state_d     = abt_pkg::ST_IDLE;
        end else begin
          if (!v && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          if (last_idx) begin
            out_valid_d = 1'b1;
            out_d       = hit_res;
            state_d     = abt_pkg::ST_IDLE;
            if (free_found_q || !v) begin
              alloc_en           = 1'b1;
              we                 = 1'b1;
              waddr              = alloc_idx;
              wdata.family       = cur_q.is_ip6;
              wdata.addr_high    = cur_q.addr_high;
              wdata.addr_low     = cur_q.addr_low;
              wdata.tbl          = cur_q.table_index;
              wdata.action       = cur_q.action_code;
              wdata.hit_count    = 16'd1;
              wdata.blocked      = 1'b0;
              wdata.seconds_left = (thr_q <= 16'd1) ? 16'd1 : arm;
              valid_d[alloc_idx] = 1'b1;
            end else begin
              out_d.status = abt_pkg::STATUS_FULL;
            end
          end else begin
            idx_d = idx_q + abt_pkg::IDX_W'(1);
          end
        end
      end
      abt_pkg::ST_TICK: begin
        if (v) begin
          we = 1'b1;
          if (e.seconds_left > 16'd1) begin
            upd.seconds_left = e.seconds_left - 16'd1;
          end else begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_valid_d = 1'b1;
            pend_d       = rule_res;
            if (is_add) begin
              upd.blocked      = 1'b1;
              upd.seconds_left = arm;
            end else begin
              valid_d[idx_q] = 1'b0;
            end
          end
          wdata = upd;
        end
        if (last_idx) begin
          state_d = abt_pkg::ST_FLUSH;
        end else begin
          idx_d = idx_q + abt_pkg::IDX_W'(1);
        end
      end
      abt_pkg::ST_FLUSH: begin
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          out_d.last  = 1'b1;
        end
        pend_valid_d = 1'b0;
        state_d      = abt_pkg::ST_IDLE;
      end
      default: begin
        state_d = abt_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we_i && (cfg_idx_i == abt_pkg::REG_ENABLE) && !cfg_wdata_i[0]) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= abt_pkg::ST_IDLE;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      free_found_q <= 1'b0;
      idx_q        <= '0;
      enable_q     <= 1'b0;
      thr_q        <= 16'd5;
      tmo_q        <= 16'd300;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      free_found_q <= free_found_d;
      idx_q        <= idx_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          abt_pkg::REG_ENABLE:    enable_q <= cfg_wdata_i[0];
          abt_pkg::REG_THRESHOLD: thr_q    <= cfg_wdata_i;
          abt_pkg::REG_TIMEOUT:   tmo_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    free_idx_q <= free_idx_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    rd_q       <= ent_q[idx_d];
    if (we) begin
      ent_q[waddr] <= wdata;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `ABT_ASSERT(a_alloc_free, alloc_en |-> !valid_q[alloc_idx], "allocating an entry in use")
  `ABT_ASSERT(a_hit_last, out_valid_q && (out_q.kind == abt_pkg::KIND_HIT) |-> out_q.last, "hit item without last")
  `ABT_ASSERT(a_flush_after_tick, (state_q == abt_pkg::ST_FLUSH) |-> ($past(state_q) == abt_pkg::ST_TICK), "flush outside a tick")

endmodule
